@@ sv/maec_pkg.sv @@
// ----------------------------------------------------------------------------
// maec_pkg
// Shared types, constants and codes for the multi-axis encoder capture block.
// ----------------------------------------------------------------------------
package maec_pkg;

    localparam int AXES      = 4;
    localparam int LIVE_AXES = (AXES < 4) ? AXES : 4;
    localparam int REG_AXES  = 4;
    localparam int NODE_W    = 7;
    localparam int DIR_LSB   = 28;

    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    localparam int ANGLE_W = 48;
    localparam int AGE_W   = 48;
    localparam int DIV_W   = 14;
    localparam int NUM_W   = AGE_W + DIV_W;
    localparam int DIGIT_W = 16;
    localparam int DIGITS  = AGE_W / DIGIT_W;
    localparam int DIVX_W  = DIV_W + DIGIT_W;
    localparam int STEP_W  = $clog2(DIGITS);
    localparam int MUL_W   = 32;

    // age = (diff * 1024 + 7812) / 15625, quotient bounded to AGE_W bits
    localparam logic [DIV_W-1:0] AGE_DIVISOR  = 14'd15625;
    localparam logic [NUM_W-1:0] AGE_ROUND    = 62'd7812;
    localparam logic [63:0]      AGE_SAT_DIFF = (64'd15625 << 38) - 64'd7;
    localparam logic [AGE_W-1:0] AGE_INVALID  = {AGE_W{1'b1}};
    localparam logic [63:0]      ROUND_HALF   = 64'h8000;

    // x / 15625 == (x * AGE_RECIP) >> RECIP_SHIFT for every x below 2^30
    localparam logic [MUL_W-1:0] AGE_RECIP   = 32'd1125899907;
    localparam int               RECIP_SHIFT = 44;

    localparam logic signed [ANGLE_W+1:0] ANGLE_HI = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [ANGLE_W+1:0] ANGLE_LO = -ANGLE_HI - 50'sd1;

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_SAMPLE  = 1'b1;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_NODE_MAP  = 3'd0;
    localparam t_reg_idx REG_OBJ_SEL   = 3'd1;
    localparam t_reg_idx REG_SCALE_01  = 3'd2;
    localparam t_reg_idx REG_SCALE_23  = 3'd3;
    localparam t_reg_idx REG_OFFSET_01 = 3'd4;
    localparam t_reg_idx REG_OFFSET_23 = 3'd5;

    typedef struct packed {
        logic               opcode;
        logic [7:0]         source_node;
        logic [15:0]        object_index;
        logic [7:0]         object_subindex;
        logic [31:0]        raw_count;
        logic signed [63:0] stamp_ns;
    } t_in_item;

    typedef struct packed {
        logic                      accepted;
        logic [1:0]                axis_number;
        logic signed [ANGLE_W-1:0] angle_q16;
        logic [AGE_W-1:0]          age_ms_q16;
        logic                      sample_valid;
        logic                      last_result;
    } t_out_item;

    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_CAPT = 9'b0_0000_0010,
        S_LOAD = 9'b0_0000_0100,
        S_MUL  = 9'b0_0000_1000,
        S_ANG  = 9'b0_0001_0000,
        S_DIV  = 9'b0_0010_0000,
        S_REM  = 9'b0_0100_0000,
        S_EMIT = 9'b0_1000_0000,
        S_OUT  = 9'b1_0000_0000
    } t_state;

endpackage

@@ sv/maec_if.sv @@
// ----------------------------------------------------------------------------
// maec_in_if / maec_out_if
// Valid/ready request channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface maec_in_if;
    logic                valid;
    logic                ready;
    maec_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface maec_out_if;
    logic                valid;
    logic                ready;
    maec_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/multi_axis_encoder_capture_top.sv @@
// ----------------------------------------------------------------------------
// multi_axis_encoder_capture_top
// Stores encoder captures per axis and reports angle and age on sample.
//
//   channel  direction  carries
//   i_in     in         capture frame (opcode 0) or sample request (opcode 1)
//   o_out    out        one result per capture, one per axis per sample
//   APB      in/out     six registers at byte address 8*i, 64-bit data
//
// A capture passes the match state after acceptance, then presents its result.
// A sample steps on each axis with a usable capture through load, multiply,
// angle, three 16-bit quotient digits of a divide and a remainder step each on
// the shared 32x32 multiplier, and emit, then presents the result; an axis
// without one goes from load to emit, one with a saturated age skips the
// digits. Input ready is low from acceptance until the final result is taken.
// The output register holds a result until taken. Reset is synchronous and
// clears the state, configuration registers and axis stores at once.
// ----------------------------------------------------------------------------
module multi_axis_encoder_capture_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    maec_in_if.sink                       i_in,
    maec_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [maec_pkg::PADDR_W-1:0]  paddr,
    input  logic [maec_pkg::PDATA_W-1:0]  pwdata,
    output logic [maec_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import maec_pkg::*;

    t_state                    r_state, n_state;
    t_in_item                  r_item;
    t_out_item                 r_out;
    logic [1:0]                r_axis;
    logic [STEP_W-1:0]         r_step;

    logic [31:0]               r_node_map;
    logic [23:0]               r_obj_sel;
    logic [63:0]               r_scale_01, r_scale_23;
    logic [63:0]               r_offset_01, r_offset_23;

    logic [31:0]               r_st_count [REG_AXES];
    logic signed [63:0]        r_st_stamp [REG_AXES];

    logic [63:0]               r_prod;
    logic [63:0]               r_diff;
    logic [ANGLE_W-1:0]        r_mag;
    logic                      r_valid;
    logic                      r_sat;
    logic signed [ANGLE_W-1:0] r_angle;
    logic [DIV_W-1:0]          r_rem;
    logic [AGE_W-1:0]          r_quo;
    logic [DIGIT_W-1:0]        r_qdig;

    logic                      in_fire;
    logic                      cfg_wr;
    t_reg_idx                  cfg_idx;
    logic                      last_axis;
    logic [63:0]               scale_pair, offset_pair;
    logic [31:0]               cur_scale;
    logic [31:0]               cur_offset;
    logic                      cur_dir;
    logic signed [63:0]        cur_stamp;
    logic                      cur_valid;
    logic                      obj_hit, node_hit, capt_hit;
    logic [1:0]                capt_axis;
    logic [63:0]               prod_rnd;
    logic [NUM_W-1:0]          age_num;
    logic [MUL_W-1:0]          mul_a, mul_b;
    logic [2*MUL_W-1:0]        mul_p;
    logic [DIVX_W-1:0]         div_x;
    logic [DIVX_W-1:0]         div_rem;
    logic signed [ANGLE_W+1:0] ang_mag;
    logic signed [ANGLE_W+1:0] ang_full;
    logic signed [ANGLE_W-1:0] ang_sat;

    assign in_fire   = i_in.valid & i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.data  = r_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[PADDR_W-1:3];

    always_comb begin
        case (cfg_idx)
            REG_NODE_MAP:  prdata = {32'd0, r_node_map};
            REG_OBJ_SEL:   prdata = {40'd0, r_obj_sel};
            REG_SCALE_01:  prdata = r_scale_01;
            REG_SCALE_23:  prdata = r_scale_23;
            REG_OFFSET_01: prdata = r_offset_01;
            REG_OFFSET_23: prdata = r_offset_23;
            default:       prdata = '0;
        endcase
    end

    // per-axis operand selection
    assign last_axis   = (r_axis == 2'(LIVE_AXES - 1));
    assign scale_pair  = r_axis[1] ? r_scale_23 : r_scale_01;
    assign offset_pair = r_axis[1] ? r_offset_23 : r_offset_01;
    assign cur_scale   = r_axis[0] ? scale_pair[63:32] : scale_pair[31:0];
    assign cur_offset  = r_axis[0] ? offset_pair[63:32] : offset_pair[31:0];
    assign cur_dir     = r_node_map[DIR_LSB + int'(r_axis)];
    assign cur_stamp   = r_st_stamp[r_axis];
    assign cur_valid   = (cur_stamp > 64'sd0) && (r_item.stamp_ns >= cur_stamp);

    // capture match: lowest matching axis wins
    always_comb begin
        node_hit  = 1'b0;
        capt_axis = 2'd0;
        for (int a = LIVE_AXES - 1; a >= 0; a--) begin
            if ({1'b0, r_node_map[a*NODE_W +: NODE_W]} == r_item.source_node) begin
                node_hit  = 1'b1;
                capt_axis = 2'(a);
            end
        end
    end

    assign obj_hit  = (r_item.object_index == r_obj_sel[23:8])
                   && (r_item.object_subindex == r_obj_sel[7:0])
                   && (r_item.stamp_ns > 64'sd0);
    assign capt_hit = obj_hit & node_hit;

    assign prod_rnd = r_prod + ROUND_HALF;
    assign age_num  = {r_diff[NUM_W-11:0], 10'd0} + AGE_ROUND;

    // remainder and next 16-bit digit of the dividend
    assign div_x = {r_rem, r_quo[AGE_W-1 -: DIGIT_W]};

    // shared multiplier: angle product, then quotient digit and its back-product
    always_comb begin
        case (r_state)
            S_LOAD: begin
                mul_a = r_st_count[r_axis];
                mul_b = cur_scale;
            end
            S_DIV: begin
                mul_a = {{(MUL_W-DIVX_W){1'b0}}, div_x};
                mul_b = AGE_RECIP;
            end
            S_REM: begin
                mul_a = {{(MUL_W-DIGIT_W){1'b0}}, r_qdig};
                mul_b = {{(MUL_W-DIV_W){1'b0}}, AGE_DIVISOR};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = 64'(mul_a) * 64'(mul_b);
    assign div_rem = div_x - mul_p[DIVX_W-1:0];

    always_comb begin
        ang_mag  = $signed({2'b00, r_mag});
        if (cur_dir) begin
            ang_mag = -ang_mag;
        end
        ang_full = ang_mag - $signed({{(ANGLE_W-30){cur_offset[31]}}, cur_offset});
        if (ang_full > ANGLE_HI) begin
            ang_sat = ANGLE_HI[ANGLE_W-1:0];
        end else if (ang_full < ANGLE_LO) begin
            ang_sat = ANGLE_LO[ANGLE_W-1:0];
        end else begin
            ang_sat = ang_full[ANGLE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (i_in.data.opcode == OP_SAMPLE) ? S_LOAD : S_CAPT;
                end
            end
            S_CAPT: n_state = S_OUT;
            S_LOAD: n_state = cur_valid ? S_MUL : S_EMIT;
            S_MUL:  n_state = S_ANG;
            S_ANG:  n_state = r_sat ? S_EMIT : S_DIV;
            S_DIV:  n_state = S_REM;
            S_REM: begin
                if (r_step == STEP_W'(DIGITS - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_EMIT: n_state = S_OUT;
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = r_out.last_result ? S_IDLE : S_LOAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 2'd0;
            r_step      <= '0;
            r_node_map  <= '0;
            r_obj_sel   <= '0;
            r_scale_01  <= '0;
            r_scale_23  <= '0;
            r_offset_01 <= '0;
            r_offset_23 <= '0;
            for (int i = 0; i < REG_AXES; i++) begin
                r_st_count[i] <= '0;
                r_st_stamp[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (in_fire) begin
                r_axis <= 2'd0;
            end else if (r_state == S_OUT && o_out.ready && !r_out.last_result) begin
                r_axis <= r_axis + 2'd1;
            end

            if (r_state == S_ANG) begin
                r_step <= '0;
            end else if (r_state == S_REM) begin
                r_step <= r_step + STEP_W'(1);
            end

            if (r_state == S_CAPT && capt_hit) begin
                r_st_count[capt_axis] <= r_item.raw_count;
                r_st_stamp[capt_axis] <= r_item.stamp_ns;
            end

            if (cfg_wr) begin
                case (cfg_idx)
                    REG_NODE_MAP:  r_node_map  <= pwdata[31:0];
                    REG_OBJ_SEL:   r_obj_sel   <= pwdata[23:0];
                    REG_SCALE_01:  r_scale_01  <= pwdata;
                    REG_SCALE_23:  r_scale_23  <= pwdata;
                    REG_OFFSET_01: r_offset_01 <= pwdata;
                    REG_OFFSET_23: r_offset_23 <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in.data;
        end

        case (r_state)
            S_CAPT: begin
                r_out.accepted     <= capt_hit;
                r_out.axis_number  <= capt_hit ? capt_axis : 2'd0;
                r_out.angle_q16    <= '0;
                r_out.age_ms_q16   <= '0;
                r_out.sample_valid <= 1'b0;
                r_out.last_result  <= 1'b1;
            end
            S_LOAD: begin
                r_prod  <= mul_p;
                r_diff  <= 64'(r_item.stamp_ns - cur_stamp);
                r_valid <= cur_valid;
            end
            S_MUL: begin
                r_mag <= prod_rnd[63:16];
                r_sat <= (r_diff >= AGE_SAT_DIFF);
                r_rem <= age_num[NUM_W-1:AGE_W];
                r_quo <= age_num[AGE_W-1:0];
            end
            S_ANG: begin
                r_angle <= ang_sat;
            end
            S_DIV: begin
                r_qdig <= mul_p[RECIP_SHIFT +: DIGIT_W];
            end
            S_REM: begin
                // shift the digit in and carry the remainder to the next one
                r_rem <= div_rem[DIV_W-1:0];
                r_quo <= {r_quo[AGE_W-DIGIT_W-1:0], r_qdig};
            end
            S_EMIT: begin
                r_out.accepted     <= 1'b0;
                r_out.axis_number  <= r_axis;
                r_out.angle_q16    <= r_valid ? r_angle : '0;
                r_out.age_ms_q16   <= (!r_valid || r_sat) ? AGE_INVALID : r_quo;
                r_out.sample_valid <= r_valid;
                r_out.last_result  <= last_axis;
            end
            default: ;
        endcase
    end

endmodule

@@ sv/maec_checker.sv @@
// ----------------------------------------------------------------------------
// maec_checker
// Port-level checks on the encoder capture block, bound to its top level.
// ----------------------------------------------------------------------------
module maec_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input maec_pkg::t_out_item i_out_data
);
    import maec_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // never take a request while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> !i_out_valid)
        else $error("input ready while a result is pending");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after accepting a request");

    // more results follow a non-final one
    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_data.last_result |=> !i_in_ready)
        else $error("ready before the final result");

endmodule

bind multi_axis_encoder_capture_top maec_checker u_maec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-axis encoder capture block. It sends
// capture frames and sample requests with random gaps on both channels,
// predicts each result in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import maec_pkg::*;

    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     SETTLE_CYCLES  = 8;
    localparam int     MAX_REPORTS    = 10;
    localparam int     RANDOM_ITEMS   = 36;
    localparam int     RANDOM_PHASES  = 4;

    // ns -> Q16 ms is a factor of 65536 / 1e6 = 1024 / 15625
    localparam logic [63:0] AGE_MUL  = 64'd1024;
    localparam logic [63:0] AGE_DEN  = 64'd15625;
    localparam logic [63:0] AGE_HALF = 64'd7812;
    localparam logic [63:0] AGE_SAT  = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q16_HALF = 64'h8000;
    localparam longint ANG_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ANG_MIN   = -ANG_MAX - 64'sd1;
    localparam longint STAMP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint STAMP_MIN = -STAMP_MAX - 64'sd1;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    logic                 req_valid = 1'b0;
    t_in_item             req_data  = '0;
    logic                 res_ready = 1'b0;

    maec_in_if  in_if ();
    maec_out_if out_if ();

    assign in_if.valid  = req_valid;
    assign in_if.data   = req_data;
    assign out_if.ready = res_ready;

    multi_axis_encoder_capture_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // register copies and per-axis capture store of the predictor
    logic [31:0] map_q = '0;
    logic [23:0] sel_q = '0;
    logic [31:0] scale_q  [REG_AXES] = '{default: '0};
    logic [31:0] offset_q [REG_AXES] = '{default: '0};
    logic [31:0] count_q  [REG_AXES] = '{default: '0};
    longint      stamp_q  [REG_AXES] = '{default: 0};

    t_in_item    pending_q [$];
    t_out_item   result_q  [$];   // expected results, oldest first
    t_out_item   want;

    longint      clock_ns    = 64'sd1000000;
    int          n_capt      = 0;
    int          n_stored    = 0;
    int          n_samp      = 0;
    int          n_live      = 0;
    int          n_checked   = 0;
    int          n_mismatch  = 0;
    int          tx_gap      = 0;
    int          tx_quiet    = 0;
    bit          tx_hold     = 1'b0;
    int          rx_stall    = 0;
    int          rx_quiet    = 0;
    int          idle_cycles = 0;

    // mostly short gaps, a few long ones, and now and then a quiet stretch
    function automatic int idle_len(inout int quiet);
        int pick;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) quiet = $urandom_range(8, 24);
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] spread(input bit arith);
        if (arith) return 32'($signed($urandom) >>> $urandom_range(0, 31));
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic t_in_item capture_req(input logic [7:0] node,
                                             input logic [15:0] idx,
                                             input logic [7:0] sub,
                                             input logic [31:0] cnt,
                                             input longint stamp);
        t_in_item it;
        it                 = '0;
        it.opcode          = OP_CAPTURE;
        it.source_node     = node;
        it.object_index    = idx;
        it.object_subindex = sub;
        it.raw_count       = cnt;
        it.stamp_ns        = stamp;
        return it;
    endfunction

    function automatic t_in_item sample_req(input longint now);
        t_in_item it;
        it          = '0;
        it.opcode   = OP_SAMPLE;
        it.stamp_ns = now;
        return it;
    endfunction

    function automatic string show(input t_out_item r);
        return $sformatf("acc=%0b axis=%0d angle=%0d age=%h valid=%0b last=%0b",
                         r.accepted, r.axis_number, r.angle_q16, r.age_ms_q16,
                         r.sample_valid, r.last_result);
    endfunction

    // work out the results of one request and update the capture store
    function automatic void predict_results(input t_in_item it);
        int          a;
        int          axis;
        t_out_item   r;
        logic [63:0] prod;
        logic [63:0] mag;
        logic [63:0] diff;
        logic [63:0] age;
        longint      ang;
        axis = -1;
        if (it.opcode == OP_CAPTURE) begin
            n_capt++;
            r = '0;
            r.last_result = 1'b1;
            if (it.object_index == sel_q[23:8] && it.object_subindex == sel_q[7:0]
                    && it.stamp_ns > 0) begin
                // lowest matching axis wins
                for (a = 0; a < LIVE_AXES; a++) begin
                    if (axis < 0 && {1'b0, map_q[NODE_W*a +: NODE_W]} == it.source_node)
                        axis = a;
                end
            end
            if (axis >= 0) begin
                n_stored++;
                count_q[axis] = it.raw_count;
                stamp_q[axis] = it.stamp_ns;
                r.accepted    = 1'b1;
                r.axis_number = 2'(axis);
            end
            result_q.push_back(r);
        end else begin
            n_samp++;
            for (a = 0; a < LIVE_AXES; a++) begin
                r = '0;
                r.axis_number = 2'(a);
                r.last_result = (a == LIVE_AXES - 1);
                if (stamp_q[a] <= 0 || it.stamp_ns < stamp_q[a]) begin
                    r.age_ms_q16 = AGE_INVALID;
                end else begin
                    n_live++;
                    prod = 64'(count_q[a]) * 64'(scale_q[a]);
                    mag  = (prod + Q16_HALF) >> 16;
                    ang  = longint'(mag);
                    if (map_q[DIR_LSB + a]) ang = -ang;
                    ang = ang - longint'(signed'(offset_q[a]));
                    if (ang > ANG_MAX) ang = ANG_MAX;
                    else if (ang < ANG_MIN) ang = ANG_MIN;

                    diff = 64'(it.stamp_ns - stamp_q[a]);
                    age  = (diff / AGE_DEN) * AGE_MUL
                         + ((diff % AGE_DEN) * AGE_MUL + AGE_HALF) / AGE_DEN;
                    if (age > AGE_SAT) age = AGE_SAT;

                    r.angle_q16    = ang[ANGLE_W-1:0];
                    r.age_ms_q16   = age[AGE_W-1:0];
                    r.sample_valid = 1'b1;
                end
                result_q.push_back(r);
            end
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && in_if.ready) begin
                predict_results(req_data);
                // now and then wait for every result before the next request
                if ($urandom_range(0, 29) == 0) tx_hold = 1'b1;
            end
            if (tx_hold && result_q.size() == 0) tx_hold = 1'b0;
            if (!req_valid || in_if.ready) begin
                if (tx_gap > 0 || tx_hold || pending_q.size() == 0) begin
                    if (tx_gap > 0 && in_if.ready) tx_gap--;
                    req_valid <= 1'b0;
                end else begin
                    req_valid <= 1'b1;
                    req_data  <= pending_q.pop_front();
                    tx_gap     = idle_len(tx_quiet);
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (out_if.valid && res_ready) begin
                n_checked++;
                if (result_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("unexpected result: %s", show(out_if.data));
                end else begin
                    want = result_q.pop_front();
                    if (out_if.data.accepted !== want.accepted
                            || out_if.data.axis_number !== want.axis_number
                            || out_if.data.angle_q16 !== want.angle_q16
                            || out_if.data.age_ms_q16 !== want.age_ms_q16
                            || out_if.data.sample_valid !== want.sample_valid
                            || out_if.data.last_result !== want.last_result) begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_REPORTS) begin
                            $display("result mismatch %0d at %0t", n_mismatch, $realtime);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(out_if.data));
                        end
                    end
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                res_ready <= 1'b0;
            end else begin
                if ((out_if.valid && res_ready) || $urandom_range(0, 7) == 0)
                    rx_stall = idle_len(rx_quiet);
                res_ready <= (rx_stall == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_valid && in_if.ready) || (out_if.valid && res_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NODE_MAP:  map_q = value[31:0];
            REG_OBJ_SEL:   sel_q = value[23:0];
            REG_SCALE_01:  {scale_q[1], scale_q[0]} = value;
            REG_SCALE_23:  {scale_q[3], scale_q[2]} = value;
            REG_OFFSET_01: {offset_q[1], offset_q[0]} = value;
            REG_OFFSET_23: {offset_q[3], offset_q[2]} = value;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [31:0] nmap, input logic [23:0] osel,
                                input logic [63:0] s01, input logic [63:0] s23,
                                input logic [63:0] o01, input logic [63:0] o23);
        write_reg(REG_NODE_MAP, 64'(nmap));
        write_reg(REG_OBJ_SEL, 64'(osel));
        write_reg(REG_SCALE_01, s01);
        write_reg(REG_SCALE_23, s23);
        write_reg(REG_OFFSET_01, o01);
        write_reg(REG_OFFSET_23, o23);
    endtask

    task automatic random_regs();
        logic [6:0] node [REG_AXES];
        int         a;
        for (a = 0; a < REG_AXES; a++) begin
            // duplicate node numbers now and then
            if (a > 0 && $urandom_range(0, 3) == 0) node[a] = node[a-1];
            else node[a] = 7'($urandom);
        end
        program_regs({4'($urandom), node[3], node[2], node[1], node[0]}, 24'($urandom),
                     {spread(0), spread(0)}, {spread(0), spread(0)},
                     {spread(1), spread(1)}, {spread(1), spread(1)});
    endtask

    // wait for the block to go idle
    task automatic settle();
        while (pending_q.size() != 0 || req_valid || result_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input int count);
        int       k;
        int       pick;
        int       a;
        longint   t;
        t_in_item it;
        for (k = 0; k < count; k++) begin
            pick     = $urandom_range(0, 99);
            a        = $urandom_range(0, REG_AXES - 1);
            clock_ns = clock_ns + longint'($urandom_range(0, 3000000));
            t        = clock_ns - longint'($urandom_range(0, 4000000));
            it       = capture_req({1'b0, map_q[NODE_W*a +: NODE_W]}, sel_q[23:8],
                                   sel_q[7:0], $urandom, t);
            if (pick < 45) begin
                // keep the well-formed frame
            end else if (pick < 75) begin
                it = sample_req(clock_ns);
            end else if (pick < 82) begin
                // jump far ahead, or fall back behind the stored captures
                if ($urandom_range(0, 1) != 0)
                    t = clock_ns + (longint'($urandom) << $urandom_range(0, 31));
                else
                    t = clock_ns - longint'($urandom_range(0, 8000000));
                it = sample_req(t);
            end else if (pick < 92) begin
                // spoil one field of a well-formed frame
                case ($urandom_range(0, 3))
                    0: it.object_index    = it.object_index ^ 16'(1 << $urandom_range(0, 15));
                    1: it.object_subindex = it.object_subindex ^ 8'(1 << $urandom_range(0, 7));
                    2: it.stamp_ns        = -longint'($urandom);
                    default: it.source_node = {1'b1, it.source_node[6:0]};
                endcase
            end else begin
                it.opcode          = 1'($urandom);
                it.source_node     = 8'($urandom);
                it.object_index    = 16'($urandom);
                it.object_subindex = 8'($urandom);
                it.raw_count       = $urandom;
                it.stamp_ns        = {$urandom, $urandom};
            end
            pending_q.push_back(it);
        end
    endtask

    initial begin
        int ph;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: every axis has node 0, axis 0 takes the frame
        pending_q.push_back(sample_req(64'sd5));
        pending_q.push_back(capture_req(8'd0, 16'h0000, 8'h00, 32'hFFFF_FFFF, 64'sd1));
        pending_q.push_back(capture_req(8'd0, 16'h0000, 8'h00, 32'd1, 64'sd0));
        pending_q.push_back(capture_req(8'd0, 16'h0000, 8'h00, 32'd1, STAMP_MIN));
        pending_q.push_back(capture_req(8'h80, 16'h0000, 8'h00, 32'd1, 64'sd10));
        pending_q.push_back(sample_req(64'sd0));
        pending_q.push_back(sample_req(64'sd1));
        settle();

        // extremes: duplicate nodes, node 127, full scales, offsets at both ends
        program_regs({4'b1010, 7'd0, 7'd5, 7'd5, 7'd127}, 24'hFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFF, {32'h0000_0001, 32'h8000_0000},
                     {32'h7FFF_FFFF, 32'h8000_0000}, {32'hFFFF_FFFF, 32'h0000_0000});
        pending_q.push_back(capture_req(8'd127, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 64'sd100));
        pending_q.push_back(capture_req(8'd5, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, STAMP_MAX));
        pending_q.push_back(capture_req(8'd0, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 64'sd50));
        pending_q.push_back(capture_req(8'd255, 16'hFFFF, 8'hFF, 32'd7, 64'sd60));
        pending_q.push_back(capture_req(8'd127, 16'hFFFE, 8'hFF, 32'd7, 64'sd60));
        pending_q.push_back(capture_req(8'd127, 16'hFFFF, 8'h7F, 32'd7, 64'sd60));
        pending_q.push_back(sample_req(64'sd100));
        pending_q.push_back(sample_req(STAMP_MAX));
        settle();

        // rounding of halves in angle and age
        program_regs({4'b0000, 7'd4, 7'd3, 7'd2, 7'd1}, 24'h12_3456,
                     {32'h0000_8000, 32'h0000_7FFF}, {32'h7FFF_8000, 32'h0001_8000},
                     64'd0, 64'd0);
        pending_q.push_back(capture_req(8'd1, 16'h1234, 8'h56, 32'd1, 64'sd1000));
        pending_q.push_back(capture_req(8'd2, 16'h1234, 8'h56, 32'd1, 64'sd1000));
        pending_q.push_back(capture_req(8'd3, 16'h1234, 8'h56, 32'd1, 64'sd1000));
        pending_q.push_back(capture_req(8'd4, 16'h1234, 8'h56, 32'd3, 64'sd1000));
        pending_q.push_back(sample_req(64'sd1007));
        pending_q.push_back(sample_req(64'sd1008));
        settle();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 1)
                program_regs('1, '1, '1, '1, {32'h8000_0000, 32'h7FFF_FFFF},
                             {32'h7FFF_FFFF, 32'h8000_0000});
            else
                random_regs();
            random_phase(RANDOM_ITEMS);
            settle();
        end

        $display("covered %0d captures (%0d stored) and %0d samples (%0d live axis results)",
                 n_capt, n_stored, n_samp, n_live);
        $display("checked %0d results, %0d bad, %0d still outstanding",
                 n_checked, n_mismatch, result_q.size());
        if (n_mismatch == 0 && result_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
sv/maec_pkg.sv
sv/maec_if.sv
sv/multi_axis_encoder_capture_top.sv
sv/maec_checker.sv
tb/sv/tb_top.sv
